// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define AST_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/bgi_pkg.sv
package bgi_pkg;

  localparam int VAL_W      = 32;
  localparam int IDX_W      = 6;
  localparam int AXIS_DEPTH = 64;
  localparam int GRID_DEPTH = 4096;
  localparam int CNT_W      = 7;
  localparam int FRAC_W     = 17;
  localparam int DIV_STEPS  = 16;

  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  localparam logic [1:0] KIND_LOAD_X = 2'd0;
  localparam logic [1:0] KIND_LOAD_Y = 2'd1;
  localparam logic [1:0] KIND_LOAD_G = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_AREQ0,
    ST_AREQ1,
    ST_AREQ2,
    ST_RANGE,
    ST_DIVX,
    ST_WAITX,
    ST_DIVY,
    ST_WAITY,
    ST_GRID,
    ST_LERP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] amin;
    logic signed [VAL_W-1:0] amax;
    logic [IDX_W-1:0]        cell_idx;
  } scan_res_t;

endpackage

// File: sv/bgi_ram.sv
module bgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bgi_axis_scan.sv
module bgi_axis_scan import bgi_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [IDX_W-1:0]        k,
  input  logic [IDX_W-1:0]        n_m1,
  input  logic signed [VAL_W-1:0] q,
  input  logic signed [VAL_W-1:0] a,
  output scan_res_t               res
);

  logic found;
  logic first;
  logic found_cur;

  assign first     = (k == '0);
  assign found_cur = first ? 1'b0 : found;

  always_ff @(posedge clk) begin
    if (en) begin
      if (first) begin
        res.amin <= a;
        res.amax <= a;
      end else begin
        if (a < res.amin) begin
          res.amin <= a;
        end
        if (a > res.amax) begin
          res.amax <= a;
        end
      end
      found <= found_cur;
      if (!found_cur) begin
        if (q == a) begin
          res.cell_idx <= (k == n_m1) ? k - 1'b1 : k;
          found        <= 1'b1;
        end else if (q < a) begin
          res.cell_idx <= first ? '0 : k - 1'b1;
          found        <= 1'b1;
        end else if (k == n_m1) begin
          res.cell_idx <= n_m1 - 1'b1;
          found        <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/bgi_frac_div.sv
module bgi_frac_div import bgi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [VAL_W:0] num,
  input  logic signed [VAL_W:0] den,
  output logic                  done,
  output logic [FRAC_W-1:0]     frac
);

  logic                 busy;
  logic [4:0]           cnt;
  logic [VAL_W:0]       rem;
  logic [VAL_W:0]       den_r;
  logic [DIV_STEPS-1:0] quo;
  logic [VAL_W:0]       rem2;
  logic                 take;
  logic [DIV_STEPS-1:0] quo_next;

  assign rem2     = {rem[VAL_W-1:0], 1'b0};
  assign take     = (rem2 >= den_r);
  assign quo_next = {quo[DIV_STEPS-2:0], take};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den <= 0 || num <= 0) begin
          frac <= '0;
          done <= 1'b1;
        end else if (num >= den) begin
          frac <= FRAC_ONE;
          done <= 1'b1;
        end else begin
          rem   <= num;
          den_r <= den;
          quo   <= '0;
          cnt   <= 5'(DIV_STEPS);
          busy  <= 1'b1;
        end
      end else if (busy) begin
        rem <= take ? rem2 - den_r : rem2;
        quo <= quo_next;
        cnt <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
          frac <= {1'b0, quo_next};
        end
      end
    end
  end

endmodule

// File: sv/bilinear_grid_interpolator_top.sv
// Bilinear interpolator over a rectilinear grid of signed Q16.16 values.
// Items enter on the s_axis channel; tuser holds the kind of item. Kinds 0, 1
// and 2 load an x axis entry, a y axis entry or a grid value, give no result
// and leave the input ready. Kind 3 is a query; its result leaves on m_axis
// with the interpolated value in tdata, the outside flag in tuser and the
// query's tlast copied to tlast.
// Both counts are taken within 2..64. The cell search and min/max scan read
// one entry of each axis per cycle, a one-bit-per-cycle divider forms each of
// the two fractions, and four grid memory reads are followed by three lerps
// that share one multiplier. A point outside the axes skips the divider and
// the lerps. The input opens again in the same cycle that a result is offered.
// s_axis_tready is low while a query is at work. A finished result sits in
// the output register; the next item is taken while it waits, but a later
// query holds in its last step until the receiver takes the earlier result.
// Reset clears the control state and sets both counts to 64; the axis and
// grid memories are not cleared and must be written before they are read.
// The counts are written over the APB port at byte addresses 0 and 4.
module bilinear_grid_interpolator_top import bgi_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  // x_index, y_index, load_value, query_x, query_y, zero fill
  input  logic [111:0]  s_axis_tdata,
  // kind
  input  logic [1:0]    s_axis_tuser,
  input  logic          s_axis_tlast,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // interp_value
  output logic [31:0]   m_axis_tdata,
  // outside_grid
  output logic [0:0]    m_axis_tuser,
  output logic          m_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  state_t state, state_next;

  logic [CNT_W-1:0] x_count, y_count;
  logic [IDX_W-1:0] nx_m1, ny_m1, kmax;

  logic [IDX_W-1:0]        in_x_index, in_y_index;
  logic signed [VAL_W-1:0] in_load_value, in_query_x, in_query_y;

  logic signed [VAL_W-1:0] qx, qy;
  logic                    eob;
  logic [IDX_W-1:0]        k;
  logic                    scan_v;
  logic [IDX_W-1:0]        scan_k;
  scan_res_t               xres, yres;

  logic signed [VAL_W-1:0] ax0, ax1, ay0, ay1;
  logic [FRAC_W-1:0]       fx, fy;
  logic signed [VAL_W-1:0] g [4];
  logic [2:0]              gstep, lstep;
  logic signed [VAL_W-1:0] r0, r1;
  logic signed [50:0]      prod;
  logic signed [VAL_W:0]   mul_a;
  logic signed [FRAC_W:0]  mul_b;
  logic signed [VAL_W-1:0] sh;
  logic signed [VAL_W-1:0] res_value;
  logic                    res_out;

  logic                    in_acc, ax_we, ay_we, g_we;
  logic [IDX_W-1:0]        ax_raddr, ay_raddr;
  logic [11:0]             g_waddr, g_raddr;
  logic [VAL_W-1:0]        ax_rdata, ay_rdata, g_rdata;

  logic                    div_start, div_done;
  logic signed [VAL_W:0]   div_num, div_den;
  logic [FRAC_W-1:0]       div_frac;
  logic                    outside, out_free;

  assign in_x_index    = s_axis_tdata[5:0];
  assign in_y_index    = s_axis_tdata[11:6];
  assign in_load_value = s_axis_tdata[43:12];
  assign in_query_x    = s_axis_tdata[75:44];
  assign in_query_y    = s_axis_tdata[107:76];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_count <= 7'd64;
      y_count <= 7'd64;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        y_count <= pwdata[CNT_W-1:0];
      end else begin
        x_count <= pwdata[CNT_W-1:0];
      end
    end
  end

  assign prdata = {25'd0, paddr[2] ? y_count : x_count};

  always_comb begin
    if (x_count < 7'd2) begin
      nx_m1 = 6'd1;
    end else if (x_count > 7'(AXIS_DEPTH)) begin
      nx_m1 = 6'(AXIS_DEPTH - 1);
    end else begin
      nx_m1 = 6'(x_count - 7'd1);
    end
    if (y_count < 7'd2) begin
      ny_m1 = 6'd1;
    end else if (y_count > 7'(AXIS_DEPTH)) begin
      ny_m1 = 6'(AXIS_DEPTH - 1);
    end else begin
      ny_m1 = 6'(y_count - 7'd1);
    end
  end

  assign kmax     = (nx_m1 > ny_m1) ? nx_m1 : ny_m1;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign outside  = (qy < yres.amin) || (qy > yres.amax) ||
                    (qx < xres.amin) || (qx > xres.amax);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && s_axis_tuser == KIND_QUERY) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN:     state_next = (k == kmax) ? ST_SCAN_END : ST_SCAN;
      ST_SCAN_END: state_next = ST_AREQ0;
      ST_AREQ0:    state_next = ST_AREQ1;
      ST_AREQ1:    state_next = ST_AREQ2;
      ST_AREQ2:    state_next = ST_RANGE;
      ST_RANGE:    state_next = outside ? ST_DONE : ST_DIVX;
      ST_DIVX:     state_next = ST_WAITX;
      ST_WAITX:    state_next = div_done ? ST_DIVY : ST_WAITX;
      ST_DIVY:     state_next = ST_WAITY;
      ST_WAITY:    state_next = div_done ? ST_GRID : ST_WAITY;
      ST_GRID:     state_next = (gstep == 3'd4) ? ST_LERP : ST_GRID;
      ST_LERP:     state_next = (lstep == 3'd4) ? ST_DONE : ST_LERP;
      ST_DONE:     state_next = out_free ? ST_IDLE : ST_DONE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    in_acc        = s_axis_tready && s_axis_tvalid;
    ax_we         = in_acc && s_axis_tuser == KIND_LOAD_X;
    ay_we         = in_acc && s_axis_tuser == KIND_LOAD_Y;
    g_we          = in_acc && s_axis_tuser == KIND_LOAD_G;
    div_start     = (state == ST_DIVX) || (state == ST_DIVY);
    div_num       = (state == ST_DIVY) ? {qy[VAL_W-1], qy} - {ay0[VAL_W-1], ay0}
                                       : {qx[VAL_W-1], qx} - {ax0[VAL_W-1], ax0};
    div_den       = (state == ST_DIVY) ? {ay1[VAL_W-1], ay1} - {ay0[VAL_W-1], ay0}
                                       : {ax1[VAL_W-1], ax1} - {ax0[VAL_W-1], ax0};
    ax_raddr      = k;
    ay_raddr      = k;
    unique case (state)
      ST_AREQ0: begin
        ax_raddr = xres.cell_idx;
        ay_raddr = yres.cell_idx;
      end
      ST_AREQ1: begin
        ax_raddr = xres.cell_idx + 1'b1;
        ay_raddr = yres.cell_idx + 1'b1;
      end
      default: begin
        ax_raddr = k;
        ay_raddr = k;
      end
    endcase
    g_waddr = {in_y_index, in_x_index};
    g_raddr = {yres.cell_idx + IDX_W'(gstep[1]), xres.cell_idx + IDX_W'(gstep[0])};
    case (lstep)
      3'd0: begin
        mul_a = {g[1][VAL_W-1], g[1]} - {g[0][VAL_W-1], g[0]};
        mul_b = {1'b0, fx};
      end
      3'd1: begin
        mul_a = {g[3][VAL_W-1], g[3]} - {g[2][VAL_W-1], g[2]};
        mul_b = {1'b0, fx};
      end
      default: begin
        mul_a = {r1[VAL_W-1], r1} - {r0[VAL_W-1], r0};
        mul_b = {1'b0, fy};
      end
    endcase
    sh = prod[47:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      scan_v        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      scan_v <= (state == ST_SCAN);
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_k <= k;
    if (in_acc) begin
      qx  <= in_query_x;
      qy  <= in_query_y;
      eob <= s_axis_tlast;
      k   <= '0;
    end
    if (state == ST_SCAN) begin
      k <= k + 1'b1;
    end
    if (state == ST_AREQ1) begin
      ax0 <= ax_rdata;
      ay0 <= ay_rdata;
    end
    if (state == ST_AREQ2) begin
      ax1 <= ax_rdata;
      ay1 <= ay_rdata;
    end
    if (state == ST_RANGE) begin
      res_value <= '0;
      res_out   <= 1'b1;
    end
    if (state == ST_WAITX && div_done) begin
      fx <= div_frac;
    end
    if (state == ST_WAITY && div_done) begin
      fy    <= div_frac;
      gstep <= '0;
    end
    if (state == ST_GRID) begin
      gstep <= gstep + 1'b1;
      lstep <= '0;
      if (gstep != 3'd0) begin
        g[gstep[1:0] - 2'd1] <= g_rdata;
      end
    end
    if (state == ST_LERP) begin
      lstep <= lstep + 1'b1;
      prod  <= mul_a * mul_b;
      case (lstep)
        3'd1:    r0 <= g[0] + sh;
        3'd2:    r1 <= g[2] + sh;
        3'd4: begin
          res_value <= r0 + sh;
          res_out   <= 1'b0;
        end
        default: ;
      endcase
    end
    if (state == ST_DONE && out_free) begin
      m_axis_tdata <= res_value;
      m_axis_tuser <= res_out;
      m_axis_tlast <= eob;
    end
  end

  bgi_ram #(.WIDTH(VAL_W), .DEPTH(AXIS_DEPTH)) u_xram (
    .clk(clk), .we(ax_we), .waddr(in_x_index), .wdata(in_load_value),
    .raddr(ax_raddr), .rdata(ax_rdata)
  );

  bgi_ram #(.WIDTH(VAL_W), .DEPTH(AXIS_DEPTH)) u_yram (
    .clk(clk), .we(ay_we), .waddr(in_y_index), .wdata(in_load_value),
    .raddr(ay_raddr), .rdata(ay_rdata)
  );

  bgi_ram #(.WIDTH(VAL_W), .DEPTH(GRID_DEPTH)) u_gram (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(in_load_value),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  bgi_axis_scan u_xscan (
    .clk(clk), .en(scan_v && scan_k <= nx_m1), .k(scan_k), .n_m1(nx_m1),
    .q(qx), .a(ax_rdata), .res(xres)
  );

  bgi_axis_scan u_yscan (
    .clk(clk), .en(scan_v && scan_k <= ny_m1), .k(scan_k), .n_m1(ny_m1),
    .q(qy), .a(ay_rdata), .res(yres)
  );

  bgi_frac_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .frac(div_frac)
  );

endmodule

// File: sv/bgi_checker.sv
`include "assert_macros.svh"

module bgi_checker import bgi_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic [1:0]   s_axis_tuser,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [31:0]  m_axis_tdata,
  input logic [0:0]   m_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready
);

  // A result held back by the receiver stays offered.
  `AST_CLK(a_out_hold, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid), "result dropped")
  // An outside point always reports a zero value.
  `AST_CLK(a_outside_zero, (m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0), "outside value not zero")
  // A query keeps the input side closed on the following cycle.
  `AST_CLK(a_query_busy, (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_QUERY |=> !s_axis_tready), "ready during query")
  // Reset leaves no result on the output.
  `AST_ALWAYS(a_rst_idle, (rst |=> !m_axis_tvalid), "result after reset")

endmodule

bind bilinear_grid_interpolator_top bgi_checker u_chk (.*);
